// ===== design/fcb_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fcb_pkg
// shared types and constants of the coo to csf fiber builder
// -----------------------------------------------------------------------------
package fcb_pkg;

   localparam int MAX_ORDER   = 4;
   localparam int NUM_LEVELS  = 4;
   localparam int ORDER_LIMIT = (MAX_ORDER < NUM_LEVELS) ? MAX_ORDER : NUM_LEVELS;
   localparam int INDEX_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;
   localparam int VALUE_WIDTH = 64;
   localparam int DATA_WIDTH  = 64;
   localparam int LEVEL_WIDTH = 2;
   localparam int ORDER_WIDTH = 3;
   localparam int USER_WIDTH  = 8;
   localparam int REQ_DATA_WIDTH = NUM_LEVELS * INDEX_WIDTH + VALUE_WIDTH;

   typedef enum logic [1:0] {
      KIND_INDEX   = 2'd0,
      KIND_POINTER = 2'd1,
      KIND_VALUE   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [NUM_LEVELS-1:0][INDEX_WIDTH-1:0] idx;
      logic [VALUE_WIDTH-1:0]                 value;
      logic                                   last;
      logic                                   head;
      logic                                   flag;
      logic [ORDER_WIDTH-1:0]                 order;
      logic [ORDER_WIDTH-1:0]                 start;
   } job_type;

endpackage

// ===== design/fcb_front.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fcb_front
// accepts non-zeros, finds the first changed level and the order flag
// -----------------------------------------------------------------------------
module fcb_front import fcb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ORDER_WIDTH-1:0]    tensor_order,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // level0..3 index, nonzero_value
   input  logic                      req_tlast,   // end_of_tensor
   output logic                      job_push,
   output job_type                   job,
   input  logic                      job_ready
);

   logic [NUM_LEVELS-1:0][INDEX_WIDTH-1:0] prev_ff, prev_in;
   logic                                   have_ff, have_in;
   logic [NUM_LEVELS-1:0][INDEX_WIDTH-1:0] idx;
   logic [ORDER_WIDTH-1:0]                 order;
   logic [ORDER_WIDTH-1:0]                 start;
   logic                                   flag;

   always_comb begin
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
         idx[lv] = req_tdata[lv*INDEX_WIDTH +: INDEX_WIDTH];
      end
      order = tensor_order;
      if (order == '0) begin
         order = ORDER_WIDTH'(1);
      end
      if (order > ORDER_WIDTH'(ORDER_LIMIT)) begin
         order = ORDER_WIDTH'(ORDER_LIMIT);
      end
      start = order;
      flag  = 1'b0;
      for (int lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
         if (ORDER_WIDTH'(lv) < order && idx[lv] != prev_ff[lv]) begin
            start = ORDER_WIDTH'(lv);
            flag  = idx[lv] < prev_ff[lv];
         end
      end
      if (!have_ff) begin
         start = '0;
         flag  = 1'b0;
      end

      job.idx   = idx;
      job.value = req_tdata[NUM_LEVELS*INDEX_WIDTH +: VALUE_WIDTH];
      job.last  = req_tlast;
      job.head  = !have_ff;
      job.flag  = flag;
      job.order = order;
      job.start = start;

      req_tready = job_ready;
      job_push   = req_tvalid && job_ready;

      prev_in = prev_ff;
      have_in = have_ff;
      if (job_push) begin
         for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            if (ORDER_WIDTH'(lv) >= start && ORDER_WIDTH'(lv) < order) begin
               prev_in[lv] = idx[lv];
            end
         end
         have_in = !req_tlast;
         // end of tensor clears the stored coordinates
         if (req_tlast) begin
            prev_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         have_ff <= have_in;
      end
   end

endmodule

// ===== design/fcb_queue.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fcb_queue
// two-entry queue of classified non-zeros between front and back
// -----------------------------------------------------------------------------
module fcb_queue import fcb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    push_ready,
   input  logic    pop,
   output job_type pop_job,
   output logic    pop_valid
);

   job_type    slot0_ff, slot1_ff;
   logic [1:0] count_ff;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_job    = slot0_ff;

   always_ff @(posedge clock) begin
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_ff <= push_job;
            end else begin
               slot1_ff <= push_job;
            end
         end
         2'b01: begin
            slot0_ff <= slot1_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_ff <= push_job;
            end else begin
               slot0_ff <= slot1_ff;
               slot1_ff <= push_job;
            end
         end
         default: begin
         end
      endcase
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== design/fcb_back.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fcb_back
// sequences index, pointer and value words of each non-zero, one per cycle while the output is not stalled
// -----------------------------------------------------------------------------
module fcb_back import fcb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job,
   output logic                  job_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata,   // entry_data
   output logic [USER_WIDTH-1:0] rsp_tuser,   // entry_kind, entry_level, out_of_order, zero pad
   output logic                  rsp_tlast    // last_of_run
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_IDX,
      S_PTR,
      S_VAL,
      S_FIN
   } state_type;

   state_type                              state_ff, state_in;
   logic [LEVEL_WIDTH-1:0]                 lvl_ff, lvl_in;
   job_type                                job_ff, job_in;
   logic [MAX_ORDER-1:0][COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                                   valid_ff, valid_in;
   logic [DATA_WIDTH-1:0]                  data_ff, data_in;
   logic [USER_WIDTH-1:0]                  user_ff, user_in;
   logic                                   last_ff, last_in;

   logic                   out_free;
   logic                   done;
   logic [LEVEL_WIDTH-1:0] lvl_next;
   logic                   more_levels;
   kind_type               kind;
   logic [LEVEL_WIDTH-1:0] level;
   logic                   flag;

   always_comb begin
      out_free    = !valid_ff || rsp_tready;
      lvl_next    = lvl_ff + LEVEL_WIDTH'(1);
      more_levels = (ORDER_WIDTH'(lvl_ff) + ORDER_WIDTH'(1)) < job_ff.order;

      state_in = state_ff;
      lvl_in   = lvl_ff;
      job_in   = job_ff;
      count_in = count_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      job_pop  = 1'b0;
      done     = 1'b0;
      kind     = KIND_VALUE;
      level    = '0;
      flag     = 1'b0;

      if (state_ff != S_IDLE && out_free) begin
         valid_in = 1'b1;
         last_in  = 1'b0;
         unique case (state_ff)
            S_HEAD: begin
               kind     = KIND_POINTER;
               data_in  = '0;
               state_in = S_IDX;
               lvl_in   = '0;
            end
            S_IDX: begin
               kind     = KIND_INDEX;
               level    = lvl_ff;
               data_in  = DATA_WIDTH'(job_ff.idx[lvl_ff]);
               count_in[lvl_ff] = count_ff[lvl_ff] + COUNT_WIDTH'(1);
               state_in = more_levels ? S_PTR : S_VAL;
            end
            S_PTR: begin
               kind     = KIND_POINTER;
               level    = lvl_next;
               data_in  = DATA_WIDTH'(count_ff[lvl_next]);
               state_in = S_IDX;
               lvl_in   = lvl_next;
            end
            S_VAL: begin
               kind    = KIND_VALUE;
               flag    = job_ff.flag;
               data_in = job_ff.value;
               if (job_ff.last) begin
                  state_in = S_FIN;
                  lvl_in   = '0;
               end else begin
                  last_in = 1'b1;
                  done    = 1'b1;
               end
            end
            S_FIN: begin
               kind    = KIND_POINTER;
               level   = lvl_ff;
               data_in = DATA_WIDTH'(count_ff[lvl_ff]);
               if (more_levels) begin
                  lvl_in = lvl_next;
               end else begin
                  last_in  = 1'b1;
                  done     = 1'b1;
                  count_in = '0;
               end
            end
            default: begin
            end
         endcase
         user_in = USER_WIDTH'({flag, level, kind});
         if (done) begin
            state_in = S_IDLE;
         end
      end

      if ((state_ff == S_IDLE || done) && job_valid) begin
         job_pop = 1'b1;
         job_in  = job;
         lvl_in  = job.start[LEVEL_WIDTH-1:0];
         if (job.head) begin
            state_in = S_HEAD;
         end else if (job.start < job.order) begin
            state_in = S_IDX;
         end else begin
            state_in = S_VAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff  <= lvl_in;
      job_ff  <= job_in;
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== design/coo_to_csf_fiber_builder_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// coo_to_csf_fiber_builder_core
// streams sorted coo non-zeros out as csf index, pointer and value words
// -----------------------------------------------------------------------------
// path: a taken non-zero waits in a queue slot, is loaded into the back sequencer
//    state when that sequencer is idle, and its first word then goes to the output register
// throughput: the back sequencer sends one word per cycle while rsp_tready
//    does not stall it, and loads the next non-zero while sending the last word
//    of the current one; a non-zero causes 1 to 13 words (at most 1 + 2 * order + order)
// reset: synchronous, clears the queue, counts, previous indices and
//    previous-item flag; tensor_order returns to 3
module coo_to_csf_fiber_builder_core import fcb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [ORDER_WIDTH-1:0]    csr_wr_data,  // tensor_order
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,    // level0..3 index, nonzero_value
   input  logic                      req_tlast,    // end_of_tensor
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [DATA_WIDTH-1:0]     rsp_tdata,    // entry_data
   output logic [USER_WIDTH-1:0]     rsp_tuser,    // entry_kind, entry_level, out_of_order
   output logic                      rsp_tlast     // last_of_run
);

   logic [ORDER_WIDTH-1:0] tensor_order_ff;
   logic                   push, push_ready, pop, pop_valid;
   job_type                push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         tensor_order_ff <= ORDER_WIDTH'(3);
      end else if (csr_wr_en) begin
         tensor_order_ff <= csr_wr_data;
      end
   end

   fcb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .tensor_order (tensor_order_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .job_push     (push),
      .job          (push_job),
      .job_ready    (push_ready)
   );

   fcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_job    (pop_job),
      .pop_valid  (pop_valid)
   );

   fcb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // order flag only rides on value words
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[4] |-> rsp_tuser[1:0] == KIND_VALUE)
      else $error("out_of_order set on a non-value word");

   // a run never ends on an index word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1:0] != KIND_INDEX)
      else $error("last_of_run on an index word");

   // value words carry level zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_VALUE |-> rsp_tuser[3:2] == 2'd0)
      else $error("value word with nonzero level");

   // the back never pops an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");
`endif

endmodule
